// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// Define SYNTH to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, prop, msg)
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg)
`endif

`endif

// File: hw/rtl/cfpi_pkg.sv
// Package for the four-point cubic interpolator: widths, payload and control types.
// No dependencies.
`default_nettype none

package cfpi_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;

  // forward differences
  localparam int D1_W = SAMPLE_BITS + 1;
  localparam int D2_W = SAMPLE_BITS + 2;
  localparam int D3_W = SAMPLE_BITS + 3;

  // t-1 and t-2 scaled by 2^FRAC_BITS
  localparam int H_W = FRAC_BITS + 1;
  localparam int K_W = FRAC_BITS + 2;

  // Horner intermediates
  localparam int A_W = SAMPLE_BITS + FRAC_BITS + 5;
  localparam int C_W = SAMPLE_BITS + 2 * FRAC_BITS + 6;
  localparam int X_W = SAMPLE_BITS + 3 * FRAC_BITS + 7;

  // offset numerator after the power-of-two shift, and the final sum
  localparam int Y_W = SAMPLE_BITS + 6;
  localparam int V_W = SAMPLE_BITS + 3;

  localparam int N_STAGES = 12;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic        [FRAC_BITS-1:0]   pos_frac;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] interp_value;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic ld_pp;
    logic ld_sum;
  } mul_ctl_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_corr;
    logic ld_sat;
    logic corr_vld;
    logic out_vld;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/cfpi_wide_mul.sv
// Two-stage signed multiplier: wide operand split in halves, partial products
// registered, then summed. Depends on cfpi_pkg.
`default_nettype none

module cfpi_wide_mul #(
  parameter int WA = cfpi_pkg::A_W,
  parameter int WB = cfpi_pkg::H_W
) (
  input  wire logic                    clk,
  input  wire cfpi_pkg::mul_ctl_t      ctl,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0]      prod
);

  localparam int LO = WA / 2;
  localparam int HI = WA - LO;
  localparam int PW = WA + WB;

  logic        [LO-1:0]    a_lo;
  logic signed [HI-1:0]    a_hi;
  logic signed [LO+WB:0]   pl_nxt, pl_r;
  logic signed [HI+WB-1:0] ph_nxt, ph_r;
  logic signed [PW-1:0]    prod_nxt, prod_r;

  assign a_lo = a[LO-1:0];
  assign a_hi = a[WA-1:LO];

  always_comb begin
    pl_nxt   = $signed({1'b0, a_lo}) * b;
    ph_nxt   = a_hi * b;
    prod_nxt = $signed({ph_r, {LO{1'b0}}}) + PW'(pl_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_pp) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (ctl.ld_sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: hw/rtl/cfpi_div3_sat.sv
// Floor division by three through a reciprocal with one-step correction, add of
// sample 0, and clamp to the output range. Depends on cfpi_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cfpi_div3_sat (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire cfpi_pkg::div_ctl_t                     ctl,
  input  wire logic        [cfpi_pkg::Y_W-1:0]        y,
  input  wire logic signed [cfpi_pkg::SAMPLE_BITS-1:0] s0,
  output logic signed [cfpi_pkg::OUT_BITS-1:0]        value,
  output logic                                        sat
);

  localparam int YW = cfpi_pkg::Y_W;
  localparam int VW = cfpi_pkg::V_W;
  localparam int OB = cfpi_pkg::OUT_BITS;
  localparam int SB = cfpi_pkg::SAMPLE_BITS;

  localparam logic [YW-1:0] RECIP = YW'(((64'd1 << YW) - 64'd1) / 64'd3);
  localparam logic signed [OB-1:0] OUT_MAX = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0] OUT_MIN = {1'b1, {(OB-1){1'b0}}};

  logic        [2*YW-1:0] prod;
  logic        [YW-1:0]   q0_r;
  logic        [2:0]      ylo_r;
  logic signed [SB-1:0]   s0_r;
  logic        [2:0]      rem;
  logic                   corr;
  logic        [VW-1:0]   val_nxt, val_r;
  logic                   ovf;
  logic signed [OB-1:0]   value_nxt, value_r;
  logic                   sat_r;

  // quotient estimate is low by at most one
  assign prod = y * RECIP;

  always_comb begin
    rem     = ylo_r - (q0_r[2:0] + {q0_r[1:0], 1'b0});
    corr    = (rem >= 3'd3);
    // the 2^(SAMPLE_BITS+4) offset vanishes modulo 2^VW
    val_nxt = VW'(q0_r) + VW'(corr) + VW'(s0_r);
    ovf     = val_r[VW-1] ^ val_r[VW-2];
    if (ovf) begin
      value_nxt = val_r[VW-1] ? OUT_MIN : OUT_MAX;
    end else begin
      value_nxt = val_r[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      q0_r  <= prod[2*YW-1:YW];
      ylo_r <= y[2:0];
      s0_r  <= s0;
    end
    if (ctl.ld_corr) begin
      val_r <= val_nxt;
    end
    if (ctl.ld_sat) begin
      value_r <= value_nxt;
      sat_r   <= ovf;
    end
  end

  assign value = value_r;
  assign sat   = sat_r;

  `ASSERT_CLKRST(a_rem_range, clk, rst_n, ctl.corr_vld |-> (rem < 3'd6), "reciprocal remainder out of range")
  `ASSERT_CLKRST(a_sat_bound, clk, rst_n, ctl.out_vld && sat_r |-> ((value_r == OUT_MAX) || (value_r == OUT_MIN)), "clipped value not at a bound")

endmodule

`default_nettype wire

// File: hw/rtl/cubic_four_point_interpolator.sv
// Four-point cubic interpolator top: differences, Horner chain, final scaling.
// Depends on cfpi_pkg, cfpi_wide_mul, cfpi_div3_sat, assert_macros.svh.
// Pipeline: 12 register stages; out_valid is the valid bit of the last stage.
// Throughput: one transaction per cycle while out_ready is high or a stage is empty.
// Depth is set by the two split wide multipliers and the divide-by-three stages.
// Reset clears all stage valid bits; no other state.
`default_nettype none
`include "assert_macros.svh"

module cubic_four_point_interpolator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cfpi_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cfpi_pkg::out_item_t        out_data
);

  localparam int SB   = cfpi_pkg::SAMPLE_BITS;
  localparam int FB   = cfpi_pkg::FRAC_BITS;
  localparam int D1_W = cfpi_pkg::D1_W;
  localparam int D2_W = cfpi_pkg::D2_W;
  localparam int D3_W = cfpi_pkg::D3_W;
  localparam int A_W  = cfpi_pkg::A_W;
  localparam int C_W  = cfpi_pkg::C_W;
  localparam int X_W  = cfpi_pkg::X_W;
  localparam int Y_W  = cfpi_pkg::Y_W;
  localparam int NST  = cfpi_pkg::N_STAGES;

  // rounding half plus the offset that keeps the shifted numerator positive
  localparam logic [X_W-1:0] BIAS = (X_W'(3) << (3 * FB)) + (X_W'(3) << (SB + 3 * FB + 5));

  logic [NST-1:0] vld_r;
  logic [NST-1:0] ld;

  logic signed [D1_W-1:0] d1_nxt;
  logic signed [D2_W-1:0] d2_nxt;
  logic signed [D3_W-1:0] d3_nxt;
  logic signed [D1_W-1:0] d1_r [5];
  logic signed [D2_W-1:0] d2_r [2];
  logic signed [D3_W-1:0] d3_r;
  logic        [FB-1:0]   f_r [6];
  logic signed [SB-1:0]   s0_r [9];

  logic signed [A_W-1:0]  m1_nxt, m1_r;
  logic signed [A_W-1:0]  a_nxt, a_r;
  logic signed [C_W-1:0]  b_w;
  logic signed [C_W-1:0]  c_nxt, c_r;
  logic signed [X_W-1:0]  r_w;
  logic        [X_W-1:0]  x_sum;
  logic        [Y_W-1:0]  y_r;

  logic signed [cfpi_pkg::OUT_BITS-1:0] value_w;
  logic                                 sat_w;

  cfpi_pkg::mul_ctl_t mb_ctl, mr_ctl;
  cfpi_pkg::div_ctl_t dv_ctl;

  // stage i may load when any stage from i onward is empty or the output drains
  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_ld
      assign ld[g] = out_ready | ~(&vld_r[NST-1:g]);
    end
  endgenerate

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_comb begin
    d1_nxt = D1_W'(in_data.sample_1) - D1_W'(in_data.sample_0);
    d2_nxt = D2_W'(in_data.sample_2) - (D2_W'(in_data.sample_1) <<< 1)
           + D2_W'(in_data.sample_0);
    d3_nxt = D3_W'(in_data.sample_3) - D3_W'(in_data.sample_2)
           - (D3_W'(in_data.sample_2) <<< 1) + D3_W'(in_data.sample_1)
           + (D3_W'(in_data.sample_1) <<< 1) - D3_W'(in_data.sample_0);
    // (t-2) * d3, with t-2 = {2'b10, f} scaled by 2^FB
    m1_nxt = $signed({2'b10, f_r[0]}) * d3_r;
    a_nxt  = (A_W'(d2_r[1]) <<< FB) + (A_W'(d2_r[1]) <<< (FB + 1)) + m1_r;
    c_nxt  = b_w + (C_W'(d1_r[4]) <<< (2 * FB + 1)) + (C_W'(d1_r[4]) <<< (2 * FB + 2));
    x_sum  = X_W'(unsigned'(r_w)) + BIAS;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d1_r[0] <= d1_nxt;
      d2_r[0] <= d2_nxt;
      d3_r    <= d3_nxt;
      f_r[0]  <= in_data.pos_frac;
      s0_r[0] <= in_data.sample_0;
    end
    if (ld[1]) begin
      m1_r    <= m1_nxt;
      d2_r[1] <= d2_r[0];
    end
    if (ld[2]) begin
      a_r <= a_nxt;
    end
    if (ld[5]) begin
      c_r <= c_nxt;
    end
    if (ld[8]) begin
      y_r <= x_sum[X_W-1:3*FB+1];
    end
    for (int i = 1; i < 5; i++) begin
      if (ld[i]) begin
        d1_r[i] <= d1_r[i-1];
      end
    end
    for (int i = 1; i < 6; i++) begin
      if (ld[i]) begin
        f_r[i] <= f_r[i-1];
      end
    end
    for (int i = 1; i < 9; i++) begin
      if (ld[i]) begin
        s0_r[i] <= s0_r[i-1];
      end
    end
  end

  assign mb_ctl = '{ld_pp: ld[3], ld_sum: ld[4]};
  assign mr_ctl = '{ld_pp: ld[6], ld_sum: ld[7]};
  assign dv_ctl = '{ld_mul: ld[9], ld_corr: ld[10], ld_sat: ld[11],
                    corr_vld: vld_r[9], out_vld: vld_r[11]};

  // (t-1) * (3*d2 + (t-2)*d3), with t-1 = {1'b1, f}
  cfpi_wide_mul #(
    .WA(A_W),
    .WB(cfpi_pkg::H_W)
  ) u_mul_b (
    .clk  (clk),
    .ctl  (mb_ctl),
    .a    (a_r),
    .b    ($signed({1'b1, f_r[2]})),
    .prod (b_w)
  );

  cfpi_wide_mul #(
    .WA(C_W),
    .WB(FB + 1)
  ) u_mul_r (
    .clk  (clk),
    .ctl  (mr_ctl),
    .a    (c_r),
    .b    ($signed({1'b0, f_r[5]})),
    .prod (r_w)
  );

  cfpi_div3_sat u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dv_ctl),
    .y     (y_r),
    .s0    (s0_r[8]),
    .value (value_w),
    .sat   (sat_w)
  );

  assign out_data.interp_value = value_w;
  assign out_data.saturated    = sat_w;

  `ASSERT_CLK(a_ready_when_empty, clk, !vld_r[NST-1] |-> in_ready, "input stalled with empty output stage")
  `ASSERT_CLKRST(a_fill, clk, rst_n, in_valid && in_ready && !(out_valid && out_ready) |=> $countones(vld_r) == $past($countones(vld_r)) + 1, "transaction lost on entry")
  `ASSERT_CLKRST(a_drain, clk, rst_n, !(in_valid && in_ready) && out_valid && out_ready |=> $countones(vld_r) == $past($countones(vld_r)) - 1, "transaction repeated on exit")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for cubic_four_point_interpolator: directed table, then random transactions,
// each result checked against its table value or a cubic predictor. Depends on cfpi_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_BITS  = cfpi_pkg::SAMPLE_BITS;
  localparam int FRAC_BITS    = cfpi_pkg::FRAC_BITS;
  localparam int OUT_BITS     = cfpi_pkg::OUT_BITS;
  localparam int N_STAGES     = cfpi_pkg::N_STAGES;
  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_LIMIT   = 1000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    cfpi_pkg::in_item_t  item;
    logic                known;
    cfpi_pkg::out_item_t want;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  cfpi_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  cfpi_pkg::out_item_t out_data;

  cfpi_pkg::out_item_t pending_values[$];
  row_t                dir_rows[$];
  cfpi_pkg::out_item_t head_value;
  int                  failures = 0;
  int                  idle_cycles = 0;
  int                  quiet_left = 0;

  cubic_four_point_interpolator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // exact Newton-form cubic, rounded half up, then clamped
  function automatic cfpi_pkg::out_item_t cubic_value(input cfpi_pkg::in_item_t it);
    logic signed [127:0] s0, s1, s2, s3, f, u, d1, d2, d3, t2, r, q, qd, v, lo, hi;
    cfpi_pkg::out_item_t res;
    s0 = $signed(it.sample_0);
    s1 = $signed(it.sample_1);
    s2 = $signed(it.sample_2);
    s3 = $signed(it.sample_3);
    f  = {{(128-FRAC_BITS){1'b0}}, it.pos_frac};
    u  = 128'sd1 <<< FRAC_BITS;
    d1 = s1 - s0;
    d2 = s2 - 2 * s1 + s0;
    d3 = s3 - 3 * s2 + 3 * s1 - s0;
    t2 = f * (f - u);
    r  = 6 * u * u * f * d1 + 3 * u * t2 * d2 + t2 * (f - 2 * u) * d3 + 3 * u * u * u;
    q  = r >>> (3 * FRAC_BITS + 1);
    qd = q / 3;
    if (q < 0 && qd * 3 != q) qd = qd - 1;
    v  = s0 + qd;
    lo = -(128'sd1 <<< (OUT_BITS - 1));
    hi = (128'sd1 <<< (OUT_BITS - 1)) - 1;
    res.saturated = 1'b0;
    if (v < lo) begin
      v = lo;
      res.saturated = 1'b1;
    end else if (v > hi) begin
      v = hi;
      res.saturated = 1'b1;
    end
    res.interp_value = v[OUT_BITS-1:0];
    return res;
  endfunction

  task automatic add_row(input int a, b, c, d, input int f, input bit known,
                         input int want);
    row_t row;
    row.item.sample_0 = SAMPLE_BITS'(a);
    row.item.sample_1 = SAMPLE_BITS'(b);
    row.item.sample_2 = SAMPLE_BITS'(c);
    row.item.sample_3 = SAMPLE_BITS'(d);
    row.item.pos_frac = FRAC_BITS'(f);
    row.known = known;
    row.want.interp_value = OUT_BITS'(want);
    row.want.saturated = 1'b0;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] extreme_sample();
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic cfpi_pkg::in_item_t random_item();
    cfpi_pkg::in_item_t it;
    int base, step, bend;
    case ($urandom_range(0, 9))
      2, 3, 4, 5: begin
        base = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        step = int'($urandom_range(0, 32768)) - 16384;
        bend = int'($urandom_range(0, 2048)) - 1024;
        it.sample_0 = SAMPLE_BITS'(base);
        it.sample_1 = SAMPLE_BITS'(base + step + bend);
        it.sample_2 = SAMPLE_BITS'(base + 2 * step + 4 * bend);
        it.sample_3 = SAMPLE_BITS'(base + 3 * step + 9 * bend);
      end
      6: begin
        it.sample_0 = SAMPLE_BITS'($urandom);
        it.sample_1 = it.sample_0;
        it.sample_2 = it.sample_0;
        it.sample_3 = it.sample_0;
      end
      7: begin
        it.sample_0 = extreme_sample();
        it.sample_1 = extreme_sample();
        it.sample_2 = extreme_sample();
        it.sample_3 = extreme_sample();
      end
      8: begin
        it.sample_0 = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
        it.sample_1 = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
        it.sample_2 = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
        it.sample_3 = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      end
      default: begin
        it.sample_0 = SAMPLE_BITS'($urandom);
        it.sample_1 = SAMPLE_BITS'($urandom);
        it.sample_2 = SAMPLE_BITS'($urandom);
        it.sample_3 = SAMPLE_BITS'($urandom);
      end
    endcase
    if ($urandom_range(0, 9) < 7) begin
      it.pos_frac = FRAC_BITS'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: it.pos_frac = '0;
        1: it.pos_frac = FRAC_BITS'(1);
        2: it.pos_frac = 16'h8000;
        3: it.pos_frac = '1;
        default: it.pos_frac = 16'hFFFE;
      endcase
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (r < 3) begin
      quiet_left = $urandom_range(50, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input cfpi_pkg::in_item_t item, input bit known,
                           input cfpi_pkg::out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_values.push_back(known ? want : cubic_value(item));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_values.size() != 0);
  endtask

  initial begin
    int  hold;
    int  r;
    bit  lvl;
    hold = 0;
    lvl  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          lvl = 1'b1;
          hold = $urandom_range(100, 300);
        end else if (r < 55) begin
          lvl = 1'b1;
          hold = $urandom_range(1, 8);
        end else if (r < 93) begin
          lvl = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          hold = $urandom_range(15, 50);
        end
      end
      out_ready <= lvl;
      hold--;
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    add_row('0, '0, '0, '0, '0, 1'b1, 0);
    add_row(S_MAX, S_MAX, S_MAX, S_MAX, '1, 1'b1, S_MAX);
    add_row(S_MIN, S_MIN, S_MIN, S_MIN, '1, 1'b1, S_MIN);
    add_row(S_MAX, S_MIN, S_MAX, S_MIN, '0, 1'b1, S_MAX);
    add_row(S_MIN, S_MAX, S_MIN, S_MAX, '0, 1'b1, S_MIN);
    add_row(-1, -1, -1, -1, 16'h1234, 1'b1, -1);
    add_row(0, 16, 32, 48, 16'h8000, 1'b1, 8);
    // half-LSB ties round toward plus infinity
    add_row(0, 1, 2, 3, 16'h8000, 1'b1, 1);
    add_row(0, -1, -2, -3, 16'h8000, 1'b1, 0);
    add_row(S_MAX, S_MIN, S_MAX, S_MIN, 16'h8000, 1'b0, 0);
    add_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000, 1'b0, 0);
    add_row(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000, 1'b0, 0);
    add_row(S_MAX, S_MIN, S_MAX, S_MIN, '1, 1'b0, 0);
    add_row(S_MIN, S_MAX, S_MIN, S_MAX, '1, 1'b0, 0);
    add_row(S_MIN, S_MAX, S_MAX, S_MIN, 16'h5555, 1'b0, 0);
    add_row(S_MIN, -174763, 174762, S_MAX, '1, 1'b0, 0);
    add_row(1, 0, 0, 0, 1, 1'b0, 0);
    add_row(-1, 0, 0, 0, 1, 1'b0, 0);
    add_row(20'h5A5A5, 20'hA5A5A, 20'h0F0F0, 20'hF0F0F, 16'hAAAA, 1'b0, 0);
    add_row(20'hA5A5A, 20'h5A5A5, 20'hF0F0F, 20'h0F0F0, 16'h5555, 1'b0, 0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 600) wait_drained();
      send_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (2 * N_STAGES) @(posedge clk);
    if (pending_values.size() != 0) begin
      $error("%0d expected results never arrived", pending_values.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        $error("unexpected transaction: interp_value %0d saturated %0b",
               out_data.interp_value, out_data.saturated);
        failures++;
      end else begin
        head_value = pending_values.pop_front();
        if (out_data.interp_value !== head_value.interp_value) begin
          $error("interp_value: expected %0d, got %0d",
                 head_value.interp_value, out_data.interp_value);
          failures++;
        end
        if (out_data.saturated !== head_value.saturated) begin
          $error("saturated: expected %0b, got %0b", head_value.saturated, out_data.saturated);
          failures++;
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cfpi_pkg.sv
hw/rtl/cfpi_wide_mul.sv
hw/rtl/cfpi_div3_sat.sv
hw/rtl/cubic_four_point_interpolator.sv
dv/testbench.sv
